/* sv/rmru_pkg.sv */
// rmru_pkg: shared constants and types for the recent address list
// no dependencies; imported by every module of the block
`default_nettype none

package rmru_pkg;

    localparam int LIST_DEPTH_DEF = 32;
    localparam int MAX_RESULTS    = 32;

    localparam int ADDR_W   = 32;
    localparam int PREFIX_W = 24;
    localparam int LIMIT_W  = 6;
    localparam int HOST_W   = 8;

    localparam int S_TDATA_W = 64;
    localparam int M_TDATA_W = 16;

    localparam logic [HOST_W-1:0] HOST_MIN = 8'd1;
    localparam logic [HOST_W-1:0] HOST_MAX = 8'd254;

    localparam logic KIND_NOTE  = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    // result of the shared entry compare unit
    typedef struct packed {
        logic addr_hit;    // full 32-bit match
        logic prefix_hit;  // top three octets match
        logic host_ok;     // last octet in 1..254
    } cmp_res_t;

endpackage

`default_nettype wire

/* sv/rmru_mem.sv */
// rmru_mem: entry store, one write and one registered read port
// depends on rmru_pkg
`default_nettype none

module rmru_mem
    import rmru_pkg::*;
#(
    parameter int DEPTH = LIST_DEPTH_DEF,
    parameter int IDX_W = $clog2(DEPTH)
)
(
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [IDX_W-1:0]  waddr,
    input  wire logic [ADDR_W-1:0] wdata,
    input  wire logic [IDX_W-1:0]  raddr,
    output logic      [ADDR_W-1:0] rdata
);

    logic [ADDR_W-1:0] mem_reg [DEPTH];
    logic [ADDR_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

/* sv/rmru_cmp.sv */
// rmru_cmp: shared compare unit, checks one stored entry against the key
// depends on rmru_pkg
`default_nettype none

module rmru_cmp
    import rmru_pkg::*;
(
    input  wire logic [ADDR_W-1:0] entry,
    input  wire logic [ADDR_W-1:0] key,
    output cmp_res_t               res
);

    logic hi_eq;
    logic lo_eq;

    assign hi_eq = (entry[ADDR_W-1:HOST_W] == key[ADDR_W-1:HOST_W]);
    assign lo_eq = (entry[HOST_W-1:0] == key[HOST_W-1:0]);

    always_comb
    begin
        res.addr_hit   = hi_eq && lo_eq;
        res.prefix_hit = hi_eq;
        res.host_ok    = (entry[HOST_W-1:0] >= HOST_MIN) && (entry[HOST_W-1:0] <= HOST_MAX);
    end

endmodule

`default_nettype wire

/* sv/rmru_seq.sv */
// rmru_seq: sequencer that walks the entry store for notes and queries,
// plus the pending-hit and output registers; depends on rmru_pkg
`default_nettype none

module rmru_seq
    import rmru_pkg::*;
#(
    parameter int DEPTH = LIST_DEPTH_DEF,
    parameter int IDX_W = $clog2(DEPTH),
    parameter int CNT_W = $clog2(DEPTH + 1)
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire logic                s_kind,
    input  wire logic [ADDR_W-1:0]   s_address,
    input  wire logic [PREFIX_W-1:0] s_prefix,
    input  wire logic [LIMIT_W-1:0]  s_limit,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output logic                     m_accepted,
    output logic      [HOST_W-1:0]   m_host,
    output logic                     m_host_valid,
    output logic                     m_last,
    output logic                     mem_we,
    output logic      [IDX_W-1:0]    mem_waddr,
    output logic      [ADDR_W-1:0]   mem_wdata,
    output logic      [IDX_W-1:0]    mem_raddr,
    input  wire logic [ADDR_W-1:0]   mem_rdata,
    output logic      [ADDR_W-1:0]   cmp_key,
    input  wire cmp_res_t            cmp_res
);

    typedef enum logic [1:0] {
        IDLE,
        NOTE_SCAN,
        QUERY_SCAN,
        FINISH
    } state_t;

    state_t              state_reg, state_next;
    logic [CNT_W-1:0]    idx_reg, idx_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [ADDR_W-1:0]   key_reg, key_next;
    logic [ADDR_W-1:0]   held_reg, held_next;
    logic [HOST_W-1:0]   pend_reg, pend_next;
    logic                pend_valid_reg, pend_valid_next;
    logic [LIMIT_W-1:0]  hits_reg, hits_next;
    logic [LIMIT_W-1:0]  limit_reg, limit_next;
    logic                acc_reg, acc_next;
    logic                out_valid_reg, out_valid_next;
    logic                out_accepted_reg, out_accepted_next;
    logic [HOST_W-1:0]   out_host_reg, out_host_next;
    logic                out_host_valid_reg, out_host_valid_next;
    logic                out_last_reg, out_last_next;

    logic                can_load;
    logic                at_end;
    logic                hit;
    logic [CNT_W-1:0]    idx_inc;

    assign can_load = !out_valid_reg || m_ready;
    assign idx_inc  = idx_reg + CNT_W'(1);
    assign at_end   = (idx_reg == count_reg);
    assign hit      = cmp_res.prefix_hit && cmp_res.host_ok;

    always_comb
    begin
        state_next          = state_reg;
        idx_next            = idx_reg;
        count_next          = count_reg;
        key_next            = key_reg;
        held_next           = held_reg;
        pend_next           = pend_reg;
        pend_valid_next     = pend_valid_reg;
        hits_next           = hits_reg;
        limit_next          = limit_reg;
        acc_next            = acc_reg;
        out_valid_next      = out_valid_reg && !m_ready;
        out_accepted_next   = out_accepted_reg;
        out_host_next       = out_host_reg;
        out_host_valid_next = out_host_valid_reg;
        out_last_next       = out_last_reg;
        s_ready             = 1'b0;
        mem_we              = 1'b0;
        mem_waddr           = idx_reg[IDX_W-1:0];
        mem_wdata           = held_reg;
        mem_raddr           = idx_inc[IDX_W-1:0];

        unique case (state_reg)
            IDLE:
            begin
                s_ready   = 1'b1;
                mem_raddr = '0;
                if (s_valid)
                begin
                    idx_next        = '0;
                    held_next       = s_address;
                    pend_valid_next = 1'b0;
                    hits_next       = '0;
                    limit_next      = (s_limit > LIMIT_W'(MAX_RESULTS)) ?
                                      LIMIT_W'(MAX_RESULTS) : s_limit;
                    if (s_kind == KIND_QUERY)
                    begin
                        key_next   = {s_prefix, {HOST_W{1'b0}}};
                        acc_next   = 1'b0;
                        state_next = QUERY_SCAN;
                    end
                    else
                    begin
                        key_next = s_address;
                        if ((s_address[HOST_W-1:0] >= HOST_MIN) &&
                            (s_address[HOST_W-1:0] <= HOST_MAX))
                        begin
                            acc_next   = 1'b1;
                            state_next = NOTE_SCAN;
                        end
                        else
                        begin
                            acc_next   = 1'b0;
                            state_next = FINISH;
                        end
                    end
                end
            end

            NOTE_SCAN:
            begin
                // rotate: write the carried entry here, carry the old one on
                mem_we    = 1'b1;
                held_next = mem_rdata;
                idx_next  = idx_inc;
                if (at_end)
                begin
                    count_next = count_reg + CNT_W'(1);
                    state_next = FINISH;
                end
                else if (cmp_res.addr_hit || (idx_reg == CNT_W'(DEPTH - 1)))
                begin
                    // moved to front, or full list drops its oldest entry
                    state_next = FINISH;
                end
            end

            QUERY_SCAN:
            begin
                if (at_end || (hits_reg == limit_reg))
                begin
                    state_next = FINISH;
                end
                else if (hit && pend_valid_reg && !can_load)
                begin
                    // output busy: read the same entry again
                    mem_raddr = idx_reg[IDX_W-1:0];
                end
                else
                begin
                    idx_next = idx_inc;
                    if (hit)
                    begin
                        if (pend_valid_reg)
                        begin
                            out_valid_next      = 1'b1;
                            out_accepted_next   = 1'b0;
                            out_host_next       = pend_reg;
                            out_host_valid_next = 1'b1;
                            out_last_next       = 1'b0;
                        end
                        pend_next       = mem_rdata[HOST_W-1:0];
                        pend_valid_next = 1'b1;
                        hits_next       = hits_reg + LIMIT_W'(1);
                    end
                end
            end

            FINISH:
            begin
                if (can_load)
                begin
                    out_valid_next      = 1'b1;
                    out_accepted_next   = acc_reg;
                    out_host_next       = pend_valid_reg ? pend_reg : '0;
                    out_host_valid_next = pend_valid_reg;
                    out_last_next       = 1'b1;
                    pend_valid_next     = 1'b0;
                    state_next          = IDLE;
                end
            end

            default:
            begin
                state_next = IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= IDLE;
            idx_reg            <= '0;
            count_reg          <= '0;
            key_reg            <= '0;
            held_reg           <= '0;
            pend_reg           <= '0;
            pend_valid_reg     <= 1'b0;
            hits_reg           <= '0;
            limit_reg          <= '0;
            acc_reg            <= 1'b0;
            out_valid_reg      <= 1'b0;
            out_accepted_reg   <= 1'b0;
            out_host_reg       <= '0;
            out_host_valid_reg <= 1'b0;
            out_last_reg       <= 1'b0;
        end
        else
        begin
            state_reg          <= state_next;
            idx_reg            <= idx_next;
            count_reg          <= count_next;
            key_reg            <= key_next;
            held_reg           <= held_next;
            pend_reg           <= pend_next;
            pend_valid_reg     <= pend_valid_next;
            hits_reg           <= hits_next;
            limit_reg          <= limit_next;
            acc_reg            <= acc_next;
            out_valid_reg      <= out_valid_next;
            out_accepted_reg   <= out_accepted_next;
            out_host_reg       <= out_host_next;
            out_host_valid_reg <= out_host_valid_next;
            out_last_reg       <= out_last_next;
        end
    end

    assign cmp_key      = key_reg;
    assign m_valid      = out_valid_reg;
    assign m_accepted   = out_accepted_reg;
    assign m_host       = out_host_reg;
    assign m_host_valid = out_host_valid_reg;
    assign m_last       = out_last_reg;

    // list never grows past its depth
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("entry count above list depth");

    // only a note walk changes the entry count
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != NOTE_SCAN) |=> (count_reg == $past(count_reg)))
        else $error("entry count changed outside a note");

    // an accepted note result is always a lone final result without a host
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_accepted_reg) |-> (out_last_reg && !out_host_valid_reg))
        else $error("accepted note result malformed");

    // no hit is left pending once the block is idle again
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == IDLE) |-> !pend_valid_reg)
        else $error("pending hit left behind");

    // a query never collects more hits than its limit
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == QUERY_SCAN) |-> (hits_reg <= limit_reg))
        else $error("query hits above limit");

endmodule

`default_nettype wire

/* sv/recent_address_mru_list.sv */
// walk: an accepted note visits k entries (1..LIST_DEPTH), a rejected note none
// a query walks e entries, to the list end or its limit; a new input is taken only once the
// last result of the previous one is loaded; the walk reads one entry per cycle through
// the single read port of the entry store and the shared compare unit; a stalled output pauses
// reset: entry count cleared, list empty at once; entry store itself is not cleared
// recent_address_mru_list: top level, depends on rmru_pkg, rmru_mem, rmru_cmp, rmru_seq
`default_nettype none

module recent_address_mru_list
    import rmru_pkg::*;
#(
    parameter int LIST_DEPTH = LIST_DEPTH_DEF
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    // input transaction
    input  wire logic                 s_axis_tvalid,
    output logic                      s_axis_tready,
    input  wire logic [S_TDATA_W-1:0] s_axis_tdata,  // address, prefix, host_limit, zero pad
    input  wire logic                 s_axis_tuser,  // kind: 0 note, 1 query
    // result transaction
    output logic                      m_axis_tvalid,
    input  wire logic                 m_axis_tready,
    output logic      [M_TDATA_W-1:0] m_axis_tdata,  // accepted, host, zero pad
    output logic                      m_axis_tuser,  // host_valid
    output logic                      m_axis_tlast   // last result of this input
);

    localparam int IDX_W = $clog2(LIST_DEPTH);
    localparam int CNT_W = $clog2(LIST_DEPTH + 1);

    // unpacked input fields
    logic [ADDR_W-1:0]   in_address;
    logic [PREFIX_W-1:0] in_prefix;
    logic [LIMIT_W-1:0]  in_limit;

    assign in_address = s_axis_tdata[ADDR_W-1:0];
    assign in_prefix  = s_axis_tdata[ADDR_W+PREFIX_W-1:ADDR_W];
    assign in_limit   = s_axis_tdata[ADDR_W+PREFIX_W+LIMIT_W-1:ADDR_W+PREFIX_W];

    // entry store port
    logic              mem_we;
    logic [IDX_W-1:0]  mem_waddr;
    logic [ADDR_W-1:0] mem_wdata;
    logic [IDX_W-1:0]  mem_raddr;
    logic [ADDR_W-1:0] mem_rdata;

    // compare unit
    logic [ADDR_W-1:0] cmp_key;
    cmp_res_t          cmp_res;

    // result fields
    logic              res_accepted;
    logic [HOST_W-1:0] res_host;

    rmru_mem #(
        .DEPTH (LIST_DEPTH),
        .IDX_W (IDX_W)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // one compare of the entry just read against the note address or query prefix
    rmru_cmp u_cmp (
        .entry (mem_rdata),
        .key   (cmp_key),
        .res   (cmp_res)
    );

    rmru_seq #(
        .DEPTH (LIST_DEPTH),
        .IDX_W (IDX_W),
        .CNT_W (CNT_W)
    ) u_seq (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_valid      (s_axis_tvalid),
        .s_ready      (s_axis_tready),
        .s_kind       (s_axis_tuser),
        .s_address    (in_address),
        .s_prefix     (in_prefix),
        .s_limit      (in_limit),
        .m_valid      (m_axis_tvalid),
        .m_ready      (m_axis_tready),
        .m_accepted   (res_accepted),
        .m_host       (res_host),
        .m_host_valid (m_axis_tuser),
        .m_last       (m_axis_tlast),
        .mem_we       (mem_we),
        .mem_waddr    (mem_waddr),
        .mem_wdata    (mem_wdata),
        .mem_raddr    (mem_raddr),
        .mem_rdata    (mem_rdata),
        .cmp_key      (cmp_key),
        .cmp_res      (cmp_res)
    );

    // pack result, pad to whole bytes
    assign m_axis_tdata = {{(M_TDATA_W-HOST_W-1){1'b0}}, res_host, res_accepted};

endmodule

`default_nettype wire

/* test/mru_list_checker.sv */
// mru_list_checker: watches the input and result streams of recent_address_mru_list,
// keeps its own most-recent-first address list and compares each result transaction
// depends on rmru_pkg for field widths, host range and kind codes

module mru_list_checker
    import rmru_pkg::*;
#(
    parameter int LIST_DEPTH = LIST_DEPTH_DEF
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 s_axis_tvalid,
    input  wire logic                 s_axis_tready,
    input  wire logic [S_TDATA_W-1:0] s_axis_tdata,  // address[31:0], prefix[55:32], host_limit[61:56], zero pad
    input  wire logic                 s_axis_tuser,  // kind
    input  wire logic                 m_axis_tvalid,
    input  wire logic                 m_axis_tready,
    input  wire logic [M_TDATA_W-1:0] m_axis_tdata,  // accepted[0], host[8:1], zero pad
    input  wire logic                 m_axis_tuser,  // host_valid
    input  wire logic                 m_axis_tlast,
    output int                        fail_count,
    output int                        outstanding
);

    typedef struct packed {
        logic              accepted;
        logic [HOST_W-1:0] host;
        logic              host_valid;
        logic              last;
    } mru_result_t;

    logic [ADDR_W-1:0] listed_addr [LIST_DEPTH];
    int                listed_count = 0;
    mru_result_t       expected_results [$];

    initial
    begin
        fail_count  = 0;
        outstanding = 0;
    end

    function automatic logic host_in_range(input logic [HOST_W-1:0] host);
        return host >= HOST_MIN && host <= HOST_MAX;
    endfunction

    // move-to-front update, returns the accepted flag
    function automatic logic note_address(input logic [ADDR_W-1:0] addr);
        int pos;
        if (!host_in_range(addr[HOST_W-1:0]))
            return 1'b0;
        pos = listed_count;
        for (int i = 0; i < listed_count; i++)
            if (pos == listed_count && listed_addr[i] == addr)
                pos = i;
        if (pos == listed_count)
        begin
            // full list: the oldest entry falls off
            if (listed_count >= LIST_DEPTH)
                listed_count = LIST_DEPTH - 1;
            pos = listed_count;
            listed_count++;
        end
        for (int i = pos; i > 0; i--)
            listed_addr[i] = listed_addr[i-1];
        listed_addr[0] = addr;
        return 1'b1;
    endfunction

    function automatic void predict_hosts(input logic [PREFIX_W-1:0] prefix,
                                          input logic [LIMIT_W-1:0]  host_limit);
        int                cap;
        logic [HOST_W-1:0] hits [$];
        mru_result_t       res;
        cap = (host_limit > MAX_RESULTS) ? MAX_RESULTS : int'(host_limit);
        for (int i = 0; i < listed_count; i++)
            if (hits.size() < cap && listed_addr[i][ADDR_W-1:HOST_W] == prefix
                && host_in_range(listed_addr[i][HOST_W-1:0]))
                hits.push_back(listed_addr[i][HOST_W-1:0]);
        if (hits.size() == 0)
        begin
            res = '{accepted: 1'b0, host: '0, host_valid: 1'b0, last: 1'b1};
            expected_results.push_back(res);
        end
        for (int k = 0; k < hits.size(); k++)
        begin
            res = '{accepted: 1'b0, host: hits[k], host_valid: 1'b1,
                    last: (k == hits.size() - 1)};
            expected_results.push_back(res);
        end
    endfunction

    function automatic string describe(input mru_result_t r, input logic [6:0] pad);
        return $sformatf("accepted=%0d host=%0d host_valid=%0d last=%0d pad=%0h",
                         r.accepted, r.host, r.host_valid, r.last, pad);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        mru_result_t got;
        mru_result_t want;
        mru_result_t note_res;
        logic [6:0]  pad;
        if (!rst_n)
        begin
            listed_count = 0;
            expected_results.delete();
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                got = '{accepted: m_axis_tdata[0], host: m_axis_tdata[HOST_W:1],
                        host_valid: m_axis_tuser, last: m_axis_tlast};
                pad = 7'(m_axis_tdata >> (HOST_W + 1));
                if (expected_results.size() == 0)
                begin
                    fail_count++;
                    $display("%0t: unexpected result transaction, expected none, actual %s",
                             $time, describe(got, pad));
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (got !== want || pad !== '0)
                    begin
                        fail_count++;
                        $display("%0t: result mismatch, expected %s, actual %s",
                                 $time, describe(want, '0), describe(got, pad));
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                if (s_axis_tuser == KIND_NOTE)
                begin
                    note_res = '{accepted: 1'b0, host: '0, host_valid: 1'b0, last: 1'b1};
                    note_res.accepted = note_address(s_axis_tdata[ADDR_W-1:0]);
                    expected_results.push_back(note_res);
                end
                else
                    predict_hosts(s_axis_tdata[ADDR_W +: PREFIX_W],
                                  s_axis_tdata[ADDR_W+PREFIX_W +: LIMIT_W]);
            end
        end
        outstanding = expected_results.size();
    end

endmodule

/* test/tb_recent_address_mru_list.sv */
// tb_recent_address_mru_list: stimulus and verdict for the recent address list
// depends on rmru_pkg, recent_address_mru_list and mru_list_checker

module tb_recent_address_mru_list;
    import rmru_pkg::*;

    localparam int RANDOM_ITEMS = 270;
    localparam int CALM_ITEMS   = 50;   // tail of the run with no idling on either side
    localparam int PAD_W        = S_TDATA_W - ADDR_W - PREFIX_W - LIMIT_W;

    logic                 clk   = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata;
    logic                 s_axis_tuser;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    logic [M_TDATA_W-1:0] m_axis_tdata;
    logic                 m_axis_tuser;
    logic                 m_axis_tlast;

    int fail_count;
    int outstanding;
    bit idle_on = 1'b1;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    recent_address_mru_list dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    mru_list_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .fail_count    (fail_count),
        .outstanding   (outstanding)
    );

    // result side backpressure: random stall bursts between ready stretches while idling is on
    initial
    begin
        forever
        begin
            if (idle_on && $urandom_range(0, 3) == 0)
            begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge clk);
            end
            else
            begin
                m_axis_tready <= 1'b1;
                repeat ($urandom_range(1, 16)) @(posedge clk);
            end
        end
    end

    // one input transaction, optionally preceded by an idle burst; returns at the
    // edge where it was accepted, valid still high so the next call can follow at once
    task automatic send_item(input logic                kind,
                             input logic [ADDR_W-1:0]   addr,
                             input logic [PREFIX_W-1:0] prefix,
                             input logic [LIMIT_W-1:0]  host_limit);
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= {{PAD_W{1'b0}}, host_limit, prefix, addr};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
    endtask

    // unused fields carry random junk, the block must ignore them
    task automatic send_note(input logic [ADDR_W-1:0] addr);
        send_item(KIND_NOTE, addr, PREFIX_W'($urandom), LIMIT_W'($urandom));
    endtask

    task automatic send_query(input logic [PREFIX_W-1:0] prefix,
                              input logic [LIMIT_W-1:0]  host_limit);
        send_item(KIND_QUERY, $urandom, prefix, host_limit);
    endtask

    // watchdog, far beyond the slowest legal run
    initial
    begin
        #5_000_000;
        $display("Some tests failed");
        $finish;
    end

    initial
    begin
        logic [PREFIX_W-1:0] net_pool [4];
        logic [ADDR_W-1:0]   recent_notes [$];
        logic [ADDR_W-1:0]   addr;
        logic [HOST_W-1:0]   host;
        int                  roll;

        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= KIND_NOTE;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty list, rejected host octets, duplicates, limit corners
        send_query(24'h0A0000, 6'd5);        // nothing listed yet
        send_note(32'h0A00_0000);            // host octet 0, ignored
        send_note(32'hFFFF_FFFF);            // host octet 255, ignored
        send_note(32'h0A00_0001);
        send_note(32'h0A00_00FE);
        send_note(32'h0A00_0080);
        send_note(32'hFFFF_FFFE);
        send_note(32'h0000_0001);
        send_note(32'h0A00_0001);            // already listed, moves to front
        send_query(24'h0A0000, 6'd0);        // zero limit
        send_query(24'h0A0000, 6'd1);
        send_query(24'h0A0000, 6'd2);
        send_query(24'h0A0000, 6'd63);       // limit above max is clamped
        send_query(24'h0A0000, 6'd32);
        send_query(24'hFFFFFF, 6'd33);
        send_query(24'h000000, 6'd7);
        send_query(24'h123456, 6'd32);       // no match
        send_note(32'h0A00_00FE);            // duplicate at the oldest position
        send_query(24'h0A0000, 6'd32);

        // random: a few busy subnets so matches, moves and evictions are frequent
        net_pool[0] = 24'h0A0000;
        net_pool[1] = 24'hFFFFFF;
        net_pool[2] = PREFIX_W'($urandom);
        net_pool[3] = PREFIX_W'($urandom);

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n == RANDOM_ITEMS - CALM_ITEMS)
                idle_on = 1'b0;
            roll = $urandom_range(0, 99);
            if (roll < 55)
            begin
                roll = $urandom_range(0, 99);
                if (roll < 20 && recent_notes.size() > 0)
                    addr = recent_notes[$urandom_range(0, recent_notes.size() - 1)];
                else if (roll < 30)
                    addr = $urandom;
                else
                begin
                    host = HOST_W'($urandom);
                    if (roll < 36)
                        host = $urandom_range(0, 1) ? 8'd0 : 8'd255;
                    addr = {net_pool[$urandom_range(0, 3)], host};
                end
                send_note(addr);
                recent_notes.push_back(addr);
                if (recent_notes.size() > 40)
                    void'(recent_notes.pop_front());
            end
            else
            begin
                roll = $urandom_range(0, 99);
                send_query(roll < 85 ? net_pool[$urandom_range(0, 3)] : PREFIX_W'($urandom),
                           roll[0] ? LIMIT_W'($urandom_range(0, 3)) : LIMIT_W'($urandom));
            end
        end

        s_axis_tvalid <= 1'b0;
        @(posedge clk);

        // drain, then watch a while longer for stray results
        wait (outstanding == 0);
        repeat (LIST_DEPTH_DEF + 16) @(posedge clk);

        if (fail_count == 0 && outstanding == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
